/* hw/rtl/assert_macros.svh */
// Assertion helpers for the voice activity detector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define AST_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define AST_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

/* hw/rtl/brvad_pkg.sv */
package brvad_pkg;

    localparam int MAX_BLOCK_DEF = 256;
    // Largest supported block length; the sum is sized for it
    localparam int MAX_BLOCK_MAX = 4096;
    localparam int SUM_W = 31 + $clog2(MAX_BLOCK_MAX);

    // Register indexes
    localparam logic [2:0] REG_ENABLE  = 3'd0;
    localparam logic [2:0] REG_TRIG    = 3'd1;
    localparam logic [2:0] REG_REL     = 3'd2;
    localparam logic [2:0] REG_MIN_RMS = 3'd3;
    localparam logic [2:0] REG_ATTACK  = 3'd4;
    localparam logic [2:0] REG_HANG    = 3'd5;

    // Event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_STOP  = 2'd2;

    typedef struct packed {
        logic        enable;
        logic [7:0]  trig;
        logic [7:0]  rel;
        logic [15:0] min_rms;
        logic [7:0]  attack;
        logic [7:0]  hang;
    } cfg_t;

    // Request from front to back: one classified sample
    typedef struct packed {
        logic [15:0]      pcm;
        logic             enabled;
        logic             done;
        logic [SUM_W-1:0] sum;
        logic [12:0]      count;
    } req_t;

endpackage

/* hw/rtl/brvad_front.sv */
module brvad_front #(
    parameter int MAX_BLOCK = brvad_pkg::MAX_BLOCK_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enable,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        raw_sample,
    input  logic               last_in_block,
    output logic               req_valid,
    input  logic               req_ready,
    output brvad_pkg::req_t    req
);
    localparam int CW = $clog2(MAX_BLOCK + 1);

    logic [brvad_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        acc;
    logic signed [15:0]          s;
    logic [15:0]                 mag;
    logic [31:0]                 sq;
    logic                        close;

    assign in_ready  = req_ready;
    assign req_valid = in_valid;
    assign acc       = in_valid && req_ready;

    // Square and accumulate
    always_comb
    begin
        s        = raw_sample[31:16];
        mag      = s[15] ? 16'(-s) : 16'(s);
        sq       = mag * mag;
        sum_next = sum_reg + brvad_pkg::SUM_W'(sq);
        cnt_next = cnt_reg + CW'(1);
        close    = last_in_block || (32'(cnt_next) >= 32'(MAX_BLOCK));
    end

    always_comb
    begin
        req.pcm     = raw_sample[31:16];
        req.enabled = enable;
        req.done    = enable && close;
        req.sum     = sum_next;
        req.count   = 13'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (acc && enable)
        begin
            sum_reg <= close ? '0 : sum_next;
            cnt_reg <= close ? '0 : cnt_next;
        end
    end
endmodule

/* hw/rtl/brvad_fifo.sv */
module brvad_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  brvad_pkg::req_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output brvad_pkg::req_t rd_data
);
    // Two-entry queue
    brvad_pkg::req_t mem_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end
endmodule

/* hw/rtl/brvad_back.sv */
module brvad_back (
    input  logic            clk,
    input  logic            rst_n,
    input  brvad_pkg::cfg_t cfg,
    input  logic            req_valid,
    output logic            req_ready,
    input  brvad_pkg::req_t req,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [15:0]     pcm_sample,
    output logic            block_done,
    output logic [15:0]     block_rms,
    output logic            voice_active,
    output logic [1:0]      vad_event
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_SQRT = 6'b000100,
        ST_THR  = 6'b001000,
        ST_GATE = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0]  step_reg;
    logic [brvad_pkg::SUM_W-1:0] rem_reg;
    logic [12:0] den_reg;
    logic [31:0] quo_reg;
    logic [31:0] sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [15:0] floor_reg;
    logic        gate_reg;
    logic [7:0]  att_reg, hang_reg;
    logic [23:0] trig_reg, rel_reg;
    logic [15:0] pcm_reg, rms_reg;
    logic        done_reg, act_reg;
    logic [1:0]  ev_reg;

    logic [brvad_pkg::SUM_W+12:0] shd;
    logic [31:0] sq_t;
    logic [15:0] fl;
    logic [23:0] tp, rp;
    logic [7:0]  att_inc;
    logic [19:0] fl_new;

    assign req_ready    = state_reg == ST_IDLE;
    assign out_valid    = state_reg == ST_OUT;
    assign pcm_sample   = pcm_reg;
    assign block_done   = done_reg;
    assign block_rms    = rms_reg;
    assign voice_active = act_reg;
    assign vad_event    = ev_reg;

    always_comb
    begin
        shd     = (brvad_pkg::SUM_W+13)'(den_reg) << step_reg;
        sq_t    = sq_res_reg + sq_bit_reg;
        fl      = (floor_reg == 16'd0) ? 16'd1 : floor_reg;
        tp      = (fl * cfg.trig) >> 3;
        rp      = (fl * cfg.rel) >> 3;
        att_inc = att_reg + 8'd1;
        fl_new  = (20'(floor_reg) * 20'd15 + 20'(rms_reg)) >> 4;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (req_valid) state_next = req.done ? ST_DIV : ST_OUT;
            ST_DIV:  if (step_reg == 6'd0) state_next = ST_SQRT;
            ST_SQRT: if (sq_bit_reg == 32'd0) state_next = ST_THR;
            ST_THR:  state_next = ST_GATE;
            ST_GATE: state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            floor_reg <= '0;
            gate_reg  <= 1'b0;
            att_reg   <= '0;
            hang_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // Gate update on block end
            if (state_reg == ST_GATE)
            begin
                if (!gate_reg)
                begin
                    if (24'(rms_reg) > trig_reg)
                    begin
                        if (att_inc >= cfg.attack)
                        begin
                            gate_reg <= 1'b1;
                            att_reg  <= '0;
                            hang_reg <= cfg.hang;
                        end
                        else
                            att_reg <= att_inc;
                    end
                    else
                    begin
                        att_reg   <= '0;
                        floor_reg <= fl_new[15:0];
                    end
                end
                else if (24'(rms_reg) > rel_reg)
                    hang_reg <= cfg.hang;
                else if (hang_reg != 8'd0)
                    hang_reg <= hang_reg - 8'd1;
                else
                    gate_reg <= 1'b0;
            end
        end
    end

    // Datapath: restoring divide, then digit-pair root
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                pcm_reg  <= req.enabled ? req.pcm : 16'd0;
                done_reg <= req.done;
                act_reg  <= req.enabled && gate_reg;
                ev_reg   <= brvad_pkg::EV_NONE;
                rms_reg  <= '0;
                rem_reg  <= req.sum;
                den_reg  <= req.count;
                quo_reg  <= '0;
                step_reg <= 6'd31;
            end
            ST_DIV:
            begin
                if (shd <= (brvad_pkg::SUM_W+13)'(rem_reg))
                begin
                    rem_reg <= rem_reg - brvad_pkg::SUM_W'(shd);
                    quo_reg <= quo_reg | (32'd1 << step_reg);
                end
                step_reg <= step_reg - 6'd1;
                if (step_reg == 6'd0)
                begin
                    sq_res_reg <= '0;
                    sq_bit_reg <= 32'h4000_0000;
                end
            end
            ST_SQRT:
            begin
                if (sq_bit_reg != 32'd0)
                begin
                    if (sq_v_reg >= sq_t && sq_bit_reg <= quo_reg)
                    begin
                        sq_v_reg   <= sq_v_reg - sq_t;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_res_reg <= sq_res_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                end
                else
                    rms_reg <= sq_res_reg[15:0];
            end
            ST_THR:
            begin
                trig_reg <= (tp < 24'(cfg.min_rms)) ? 24'(cfg.min_rms) : tp;
                rel_reg  <= (rp < 24'(cfg.min_rms[15:1])) ? 24'(cfg.min_rms[15:1]) : rp;
            end
            ST_GATE:
            begin
                if (!gate_reg)
                begin
                    if (24'(rms_reg) > trig_reg && att_inc >= cfg.attack)
                    begin
                        act_reg <= 1'b1;
                        ev_reg  <= brvad_pkg::EV_START;
                    end
                end
                else if (!(24'(rms_reg) > rel_reg) && hang_reg == 8'd0)
                begin
                    act_reg <= 1'b0;
                    ev_reg  <= brvad_pkg::EV_STOP;
                end
            end
            default: ;
        endcase
        if (state_reg == ST_DIV && step_reg == 6'd0)
            sq_v_reg <= quo_reg | ((shd <= (brvad_pkg::SUM_W+13)'(rem_reg)) ? 32'd1 : 32'd0);
    end
endmodule

/* hw/rtl/block_rms_voice_activity_detector_core.sv */
// Block RMS voice activity detector.
// Input channel: raw_sample (32-bit slot) and last_in_block, valid/ready.
// Output channel: one result per input: pcm_sample, block_done, block_rms,
// voice_active, vad_event, valid/ready.
// A front stage squares and accumulates each sample combinationally and
// pushes a request into a two-entry queue. The back stage finishes it:
// a plain sample goes straight to the output register; a block end runs
// a 32-step divide, a 16-step root, then a threshold and a gate state.
// The back stage takes no new request until the output accepts its
// result; its serial divider and root unit hold it busy on a block end.
// Reset clears the block sum, count, noise floor and gate; registers
// return to their defaults. A stalled receiver holds the output register
// and, once the queue fills, input ready drops; nothing is lost.
// Configuration: APB writes at byte address 4*i, reads return values.
module block_rms_voice_activity_detector_core #(
    parameter int MAX_BLOCK = brvad_pkg::MAX_BLOCK_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] raw_sample,
    input  logic        last_in_block,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] pcm_sample,
    output logic        block_done,
    output logic [15:0] block_rms,
    output logic        voice_active,
    output logic [1:0]  vad_event
);
    brvad_pkg::cfg_t cfg_reg;
    brvad_pkg::req_t f_req, q_req;
    logic f_valid, f_ready, q_valid, q_ready;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable  <= 1'b1;
            cfg_reg.trig    <= 8'd24;
            cfg_reg.rel     <= 8'd16;
            cfg_reg.min_rms <= 16'd200;
            cfg_reg.attack  <= 8'd2;
            cfg_reg.hang    <= 8'd10;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            case (idx)
                brvad_pkg::REG_ENABLE:  cfg_reg.enable  <= pwdata[0];
                brvad_pkg::REG_TRIG:    cfg_reg.trig    <= pwdata[7:0];
                brvad_pkg::REG_REL:     cfg_reg.rel     <= pwdata[7:0];
                brvad_pkg::REG_MIN_RMS: cfg_reg.min_rms <= pwdata[15:0];
                brvad_pkg::REG_ATTACK:  cfg_reg.attack  <= pwdata[7:0];
                brvad_pkg::REG_HANG:    cfg_reg.hang    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            brvad_pkg::REG_ENABLE:  prdata = {31'd0, cfg_reg.enable};
            brvad_pkg::REG_TRIG:    prdata = {24'd0, cfg_reg.trig};
            brvad_pkg::REG_REL:     prdata = {24'd0, cfg_reg.rel};
            brvad_pkg::REG_MIN_RMS: prdata = {16'd0, cfg_reg.min_rms};
            brvad_pkg::REG_ATTACK:  prdata = {24'd0, cfg_reg.attack};
            brvad_pkg::REG_HANG:    prdata = {24'd0, cfg_reg.hang};
            default:                prdata = 32'd0;
        endcase
    end

    brvad_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
        .clk, .rst_n, .enable(cfg_reg.enable),
        .in_valid, .in_ready, .raw_sample, .last_in_block,
        .req_valid(f_valid), .req_ready(f_ready), .req(f_req)
    );

    brvad_fifo u_fifo (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
    );

    brvad_back u_back (
        .clk, .rst_n, .cfg(cfg_reg),
        .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
        .out_valid, .out_ready, .pcm_sample, .block_done, .block_rms,
        .voice_active, .vad_event
    );
endmodule

/* hw/rtl/brvad_checker.sv */
`include "assert_macros.svh"

module brvad_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        block_done,
    input logic [15:0] block_rms,
    input logic        voice_active,
    input logic [1:0]  vad_event
);
    `AST_IMPL(a_rms_only_on_done, clk, rst_n, out_valid && !block_done, block_rms == 16'd0)
    `AST_IMPL(a_ev_only_on_done, clk, rst_n, out_valid && !block_done, vad_event == 2'd0)
    `AST_IMPL(a_start_active, clk, rst_n, out_valid && vad_event == 2'd1, voice_active)
    `AST_IMPL(a_stop_idle, clk, rst_n, out_valid && vad_event == 2'd2, !voice_active)
    `AST_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(block_rms))
endmodule

bind block_rms_voice_activity_detector_core brvad_checker u_checker (
    .clk, .rst_n, .out_valid, .out_ready, .block_done, .block_rms,
    .voice_active, .vad_event
);
